// File: sv/kti_pkg.sv
// ----------------------------------------------------------------------------
// Keyframe track interpolator package
// Operation and mode codes, field widths and the command and status words
// passed between the controller and the datapath.
// ----------------------------------------------------------------------------
package kti_pkg;

    // Field widths.
    localparam int OP_W    = 2;
    localparam int ROW_W   = 16;
    localparam int VAL_W   = 32;
    localparam int MODE_W  = 2;
    localparam int TIME_W  = 32;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_SET    = 2'd0;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;
    localparam logic [OP_W-1:0] OP_EVAL   = 2'd3;

    // Interpolation modes.
    localparam logic [MODE_W-1:0] MODE_STEP   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LINEAR = 2'd1;
    localparam logic [MODE_W-1:0] MODE_COSINE = 2'd2;
    localparam logic [MODE_W-1:0] MODE_RAMP   = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic scan_step;
        logic apply;
        logic div_step;
        logic weight;
        logic mul_step;
        logic out_load;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_last;
        logic need_interp;
        logic div_last;
        logic mul_last;
    } t_sts;

endpackage

// File: sv/keyframe_track_interpolator.sv
// ----------------------------------------------------------------------------
// Keyframe track interpolator
// Keyframe table with set, delete, look up and curve evaluation.
// ----------------------------------------------------------------------------
// One operation is in flight at a time. Every operation scans the whole key
// table through the single read port of the table memory, one entry per
// cycle. A set, delete, look up or an evaluation that needs no blend then
// passes through a drain of the read pipeline, an apply step and the load of
// the output register, and the controller returns to idle before the next
// word is taken. An evaluation that blends two keys adds a serial divider,
// a weight step and a shift-and-add multiplier between the apply step and
// the load of the output register. A finished word waits in the output
// register while the next item is taken; the block stalls only when a new
// result is ready and the previous word has still not been taken.
module keyframe_track_interpolator
    import kti_pkg::*;
#(
    parameter int NUM_KEYS  = 64,
    parameter int COS_STEPS = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // row[15:0], key_value[47:16], key_mode[49:48], query_time[81:50]
    input  logic [87:0] s_axis_tdata,
    // operation[1:0]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // found[0], result_value[32:1], result_mode[34:33], status[35]
    output logic [39:0] m_axis_tdata
);

    t_cmd                    cmd;
    t_sts                    sts;
    logic                    found;
    logic signed [VAL_W-1:0] result_value;
    logic [MODE_W-1:0]       result_mode;
    logic                    status;

    kti_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    kti_dp #(
        .NUM_KEYS  (NUM_KEYS),
        .COS_STEPS (COS_STEPS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_operation    (s_axis_tuser),
        .i_row          (s_axis_tdata[15:0]),
        .i_key_value    (s_axis_tdata[47:16]),
        .i_key_mode     (s_axis_tdata[49:48]),
        .i_query_time   (s_axis_tdata[81:50]),
        .o_found        (found),
        .o_result_value (result_value),
        .o_result_mode  (result_mode),
        .o_status       (status)
    );

    // Pack the output word.
    assign m_axis_tdata = {4'd0, status, result_mode, result_value, found};

endmodule

// File: sv/kti_ctrl.sv
// ----------------------------------------------------------------------------
// Keyframe track interpolator controller
// Sequences one operation through scan, update, division and multiply steps
// and owns the handshake state of both stream ports.
// ----------------------------------------------------------------------------
module kti_ctrl
    import kti_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_DRAIN, S_APPLY, S_DIV, S_WEIGHT, S_MUL, S_FINISH
    } t_state;

    t_state r_state, n_state;
    logic   r_out_vld, n_out_vld;

    // Commands follow from the state; the two loads also depend on the handshakes.
    always_comb begin
        o_cmd           = '0;
        o_cmd.load      = (r_state == S_IDLE) && i_in_valid;
        o_cmd.scan_step = (r_state == S_SCAN);
        o_cmd.apply     = (r_state == S_APPLY);
        o_cmd.div_step  = (r_state == S_DIV);
        o_cmd.weight    = (r_state == S_WEIGHT);
        o_cmd.mul_step  = (r_state == S_MUL);
        o_cmd.out_load  = (r_state == S_FINISH) && (!r_out_vld || i_out_ready);
    end

    // Next state and output word valid.
    always_comb begin
        n_state   = r_state;
        n_out_vld = r_out_vld && !i_out_ready;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_SCAN;
            end
            S_SCAN: begin
                if (i_sts.scan_last) n_state = S_DRAIN;
            end
            S_DRAIN:  n_state = S_APPLY;
            S_APPLY: begin
                n_state = i_sts.need_interp ? S_DIV : S_FINISH;
            end
            S_DIV: begin
                if (i_sts.div_last) n_state = S_WEIGHT;
            end
            S_WEIGHT: n_state = S_MUL;
            S_MUL: begin
                if (i_sts.mul_last) n_state = S_FINISH;
            end
            S_FINISH: begin
                if (o_cmd.out_load) begin
                    n_state   = S_IDLE;
                    n_out_vld = 1'b1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_vld;

endmodule

// File: sv/kti_dp.sv
// ----------------------------------------------------------------------------
// Keyframe track interpolator datapath
// Key table memory with valid flags, bounding key scan, serial divider,
// easing weight and serial multiplier, plus the result registers.
// ----------------------------------------------------------------------------
module kti_dp
    import kti_pkg::*;
#(
    parameter int NUM_KEYS  = 64,
    parameter int COS_STEPS = 256
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cmd                     i_cmd,
    output t_sts                     o_sts,
    input  logic [OP_W-1:0]          i_operation,
    input  logic [ROW_W-1:0]         i_row,
    input  logic signed [VAL_W-1:0]  i_key_value,
    input  logic [MODE_W-1:0]        i_key_mode,
    input  logic [TIME_W-1:0]        i_query_time,
    output logic                     o_found,
    output logic signed [VAL_W-1:0]  o_result_value,
    output logic [MODE_W-1:0]        o_result_mode,
    output logic                     o_status
);

    localparam int AW    = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
    localparam int CIW   = $clog2(COS_STEPS);
    localparam int CPW   = 16 + CIW + 1;
    localparam int ENT_W = ROW_W + VAL_W + MODE_W;
    localparam int ACC_W = 50;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint unsigned Q30_ONE     = 64'd1073741824;
    localparam longint unsigned SER_DIV [1:8] = '{6, 20, 42, 72, 110, 156, 210, 272};

    typedef logic [16:0] t_ease [COS_STEPS];

    // Easing table: round(65536 * sin^2(pi*i/(2*COS_STEPS))), Q30 series.
    function automatic t_ease f_ease();
        t_ease           tab;
        longint unsigned a;
        longint unsigned a2;
        longint unsigned term;
        longint unsigned su;
        longint          s;
        for (int i = 0; i < COS_STEPS; i++) begin
            a    = (HALF_PI_Q30 * longint'(i)) / COS_STEPS;
            a2   = (a * a) >> 30;
            term = a;
            s    = longint'(a);
            for (int k = 1; k <= 8; k++) begin
                term = ((term * a2) >> 30) / SER_DIV[k];
                if (k % 2 == 1) s = s - longint'(term);
                else            s = s + longint'(term);
            end
            if (s < 0) s = 0;
            if (s > longint'(Q30_ONE)) s = longint'(Q30_ONE);
            su     = longint'(s);
            tab[i] = 17'((su * su + (64'd1 << 43)) >> 44);
        end
        return tab;
    endfunction

    localparam t_ease EASE = f_ease();

    // Key table memory and valid flags.
    logic [ENT_W-1:0]    mem [NUM_KEYS];
    logic [ENT_W-1:0]    r_mem_q;
    logic [NUM_KEYS-1:0] r_valid;

    // Captured operation.
    logic [OP_W-1:0]         r_op;
    logic [ROW_W-1:0]        r_row;
    logic signed [VAL_W-1:0] r_kv;
    logic [MODE_W-1:0]       r_km;
    logic [TIME_W-1:0]       r_qt;

    // Scan state.
    logic [AW-1:0]           r_addr;
    logic                    r_rd_pend;
    logic                    r_rd_ok;
    logic [AW-1:0]           r_rd_idx;
    logic                    r_any;
    logic                    r_match;
    logic [AW-1:0]           r_midx;
    logic signed [VAL_W-1:0] r_mval;
    logic [MODE_W-1:0]       r_mmode;
    logic                    r_free;
    logic [AW-1:0]           r_fidx;
    logic                    r_lo_ok;
    logic [ROW_W-1:0]        r_lo_row;
    logic signed [VAL_W-1:0] r_lo_val;
    logic [MODE_W-1:0]       r_lo_mode;
    logic                    r_hi_ok;
    logic [ROW_W-1:0]        r_hi_row;
    logic signed [VAL_W-1:0] r_hi_val;

    // Arithmetic state.
    logic [4:0]              r_cnt;
    logic [ROW_W-1:0]        r_rem;
    logic [15:0]             r_dsh;
    logic [ROW_W-1:0]        r_span;
    logic [16:0]             r_w;
    logic signed [ACC_W-1:0] r_mc;
    logic signed [ACC_W-1:0] r_acc;
    logic                    r_interp;

    // Result of the current operation and the output word.
    logic                    r_res_found;
    logic signed [VAL_W-1:0] r_res_value;
    logic [MODE_W-1:0]       r_res_mode;
    logic                    r_res_status;
    logic                    r_out_found;
    logic signed [VAL_W-1:0] r_out_value;
    logic [MODE_W-1:0]       r_out_mode;
    logic                    r_out_status;

    logic [ROW_W-1:0]        e_row;
    logic signed [VAL_W-1:0] e_val;
    logic [MODE_W-1:0]       e_mode;
    logic [ROW_W-1:0]        cur_row;
    logic [TIME_W-1:0]       diff;
    logic [ROW_W:0]          rem2;
    logic                    ge;
    logic [CPW-1:0]          cprod;
    logic [31:0]             sq;
    logic [16:0]             w_sel;
    logic signed [VAL_W-1:0] interp_val;

    assign {e_row, e_val, e_mode} = r_mem_q;
    assign cur_row = r_qt[TIME_W-1:16];
    assign diff    = r_qt - {r_lo_row, 16'd0};
    assign rem2    = {r_rem, r_dsh[15]};
    assign ge      = (rem2 >= {1'b0, r_span});

    // Easing weight from the 16-bit fraction held in r_dsh.
    always_comb begin
        cprod = CPW'(r_dsh) * CPW'(COS_STEPS);
        sq    = 32'(r_dsh) * 32'(r_dsh);
        case (r_lo_mode)
            MODE_LINEAR: w_sel = {1'b0, r_dsh};
            MODE_COSINE: w_sel = EASE[cprod[16 +: CIW]];
            MODE_RAMP:   w_sel = {1'b0, sq[31:16]};
            default:     w_sel = '0;
        endcase
    end

    assign interp_val = r_lo_val + VAL_W'(r_acc >>> 16);

    // Status to the controller.
    assign o_sts.scan_last   = (r_addr == AW'(NUM_KEYS - 1));
    assign o_sts.need_interp = (r_op == OP_EVAL) && r_any && r_lo_ok && r_hi_ok
                               && (r_lo_mode != MODE_STEP);
    assign o_sts.div_last    = (r_cnt == 5'd15);
    assign o_sts.mul_last    = (r_cnt == 5'd16);

    // Memory read and write ports.
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_step) r_mem_q <= mem[r_addr];
        if (i_cmd.apply && r_op == OP_SET) begin
            if (r_match)     mem[r_midx] <= {r_row, r_kv, r_km};
            else if (r_free) mem[r_fidx] <= {r_row, r_kv, r_km};
        end
    end

    // Valid flags and read pipeline control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_rd_pend <= 1'b0;
        end else begin
            r_rd_pend <= i_cmd.scan_step;
            if (i_cmd.apply && r_op == OP_SET) begin
                if (!r_match && r_free) r_valid[r_fidx] <= 1'b1;
            end
            if (i_cmd.apply && r_op == OP_DELETE && r_match) r_valid[r_midx] <= 1'b0;
        end
    end

    // Capture of the operation and the bounding key scan.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_operation;
            r_row   <= i_row;
            r_kv    <= i_key_value;
            r_km    <= i_key_mode;
            r_qt    <= i_query_time;
            r_addr  <= '0;
            r_any   <= 1'b0;
            r_match <= 1'b0;
            r_free  <= 1'b0;
            r_lo_ok <= 1'b0;
            r_hi_ok <= 1'b0;
        end else begin
            if (i_cmd.scan_step) begin
                r_rd_idx <= r_addr;
                r_rd_ok  <= r_valid[r_addr];
                if (!o_sts.scan_last) r_addr <= r_addr + AW'(1);
            end
            if (r_rd_pend) begin
                if (r_rd_ok) begin
                    r_any <= 1'b1;
                    if (!r_match && e_row == r_row) begin
                        r_match <= 1'b1;
                        r_midx  <= r_rd_idx;
                        r_mval  <= e_val;
                        r_mmode <= e_mode;
                    end
                    if (e_row <= cur_row) begin
                        if (!r_lo_ok || e_row > r_lo_row) begin
                            r_lo_ok   <= 1'b1;
                            r_lo_row  <= e_row;
                            r_lo_val  <= e_val;
                            r_lo_mode <= e_mode;
                        end
                    end else if (!r_hi_ok || e_row < r_hi_row) begin
                        r_hi_ok  <= 1'b1;
                        r_hi_row <= e_row;
                        r_hi_val <= e_val;
                    end
                end else if (!r_free) begin
                    r_free <= 1'b1;
                    r_fidx <= r_rd_idx;
                end
            end
        end
    end

    // Result of the scan, divider and multiplier.
    always_ff @(posedge i_clk) begin
        if (i_cmd.apply) begin
            r_res_found  <= 1'b0;
            r_res_value  <= '0;
            r_res_mode   <= MODE_STEP;
            r_res_status <= 1'b0;
            r_interp     <= o_sts.need_interp;
            r_cnt        <= '0;
            r_rem        <= diff[31:16];
            r_dsh        <= diff[15:0];
            r_span       <= r_hi_row - r_lo_row;
            case (r_op)
                OP_SET: begin
                    r_res_found  <= r_match;
                    r_res_status <= !r_match && !r_free;
                end
                OP_DELETE: r_res_found <= r_match;
                OP_LOOKUP: begin
                    r_res_found <= r_match;
                    if (r_match) begin
                        r_res_value <= r_mval;
                        r_res_mode  <= r_mmode;
                    end
                end
                OP_EVAL: begin
                    r_res_found <= r_any;
                    if (!r_any)        r_res_value <= '0;
                    else if (!r_lo_ok) r_res_value <= r_hi_val;
                    else               r_res_value <= r_lo_val;
                end
                default: r_res_found <= 1'b0;
            endcase
        end
        // One quotient bit per cycle, restoring division.
        if (i_cmd.div_step) begin
            r_rem <= ge ? ROW_W'(rem2 - {1'b0, r_span}) : rem2[ROW_W-1:0];
            r_dsh <= {r_dsh[14:0], ge};
            r_cnt <= r_cnt + 5'd1;
        end
        if (i_cmd.weight) begin
            r_w   <= w_sel;
            r_mc  <= ACC_W'(33'(r_hi_val) - 33'(r_lo_val));
            r_acc <= '0;
            r_cnt <= '0;
        end
        // One weight bit per cycle, shift and add.
        if (i_cmd.mul_step) begin
            if (r_w[0]) r_acc <= r_acc + r_mc;
            r_mc  <= r_mc <<< 1;
            r_w   <= r_w >> 1;
            r_cnt <= r_cnt + 5'd1;
        end
        if (i_cmd.out_load) begin
            r_out_found  <= r_res_found;
            r_out_value  <= r_interp ? interp_val : r_res_value;
            r_out_mode   <= r_res_mode;
            r_out_status <= r_res_status;
        end
    end

    assign o_found        = r_out_found;
    assign o_result_value = r_out_value;
    assign o_result_mode  = r_out_mode;
    assign o_status       = r_out_status;

endmodule

// File: sv/kti_checker.sv
// ----------------------------------------------------------------------------
// Keyframe track interpolator checker
// Port-level properties of the interpolator, bound to the top level.
// ----------------------------------------------------------------------------
module kti_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata
);

    // No output word survives reset.
    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output word valid after reset");

    // A stalled output word holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled output word changed");

    // An accepted word keeps the block busy on the next cycle.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken again while busy");

    // A refused set reports nothing else.
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[35] |->
            !m_axis_tdata[0] && m_axis_tdata[32:1] == 32'd0 && m_axis_tdata[34:33] == 2'd0)
        else $error("refused set carries data");

    // A key mode is only returned for a found key.
    a_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[34:33] != 2'd0 |-> m_axis_tdata[0])
        else $error("mode returned without a key");

endmodule

bind keyframe_track_interpolator kti_checker u_kti_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// File: sim/keyframe_track_interpolator_test.sv
// ----------------------------------------------------------------------------
// Keyframe track interpolator testbench
// Drives set, delete, look up and evaluate words into the keyframe table and
// checks every result word against an independent prediction of the table
// and of the four interpolation curves. Both sides idle at random in phases.
// ----------------------------------------------------------------------------
module keyframe_track_interpolator_test;
    import kti_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_KEYS   = 64;
    localparam int COS_STEPS  = 256;
    localparam int CYCLE_LIMIT = 600000;
    localparam int POOL_SIZE  = 96;

    typedef struct packed {
        logic              found;
        logic [VAL_W-1:0]  value;
        logic [MODE_W-1:0] mode;
        logic              status;
    } t_result;

    // Keeps its own copy of the key table and predicts each result word.
    class keyframe_scoreboard;
        logic [ROW_W-1:0]  key_row [NUM_KEYS];
        logic [VAL_W-1:0]  key_val [NUM_KEYS];
        logic [MODE_W-1:0] key_mode[NUM_KEYS];
        bit                key_used[NUM_KEYS];
        longint unsigned   ease[COS_STEPS];
        t_result           pending[$];
        int                mismatches;
        int                occupancy;

        function new();
            longint unsigned angle, s;
            mismatches = 0;
            occupancy  = 0;
            foreach (key_used[i]) key_used[i] = 0;
            for (int i = 0; i < COS_STEPS; i++) begin
                angle   = (64'd1686629713 * i) / COS_STEPS;
                s       = longint'(sine_q30(angle));
                ease[i] = (s * s + (64'd1 << 43)) >> 44;
            end
        endfunction

        // Taylor series sine of a Q30 angle in 0..pi/2.
        function longint sine_q30(longint unsigned a);
            longint unsigned a2, term;
            longint s;
            a2   = (a * a) >> 30;
            term = a;
            s    = longint'(a);
            for (int k = 1; k <= 8; k++) begin
                term = ((term * a2) >> 30) / longint'((2 * k) * (2 * k + 1));
                if (k % 2 == 1) s -= longint'(term);
                else s += longint'(term);
            end
            if (s < 0) s = 0;
            if (s > 64'd1073741824) s = 64'd1073741824;
            return s;
        endfunction

        function int slot_of(logic [ROW_W-1:0] row);
            for (int i = 0; i < NUM_KEYS; i++)
                if (key_used[i] && key_row[i] == row) return i;
            return -1;
        endfunction

        // Samples the curve at a Q16.16 time; any reports a non-empty table.
        function longint sample_curve(logic [TIME_W-1:0] qtime, output bit any);
            int lo, hi;
            longint unsigned t, w, span, diff;
            longint vl, vu;
            logic [15:0] cur;
            cur = qtime[31:16];
            lo  = -1;
            hi  = -1;
            any = 0;
            for (int i = 0; i < NUM_KEYS; i++) begin
                if (!key_used[i]) continue;
                any = 1;
                if (key_row[i] <= cur) begin
                    if (lo < 0 || key_row[i] > key_row[lo]) lo = i;
                end else begin
                    if (hi < 0 || key_row[i] < key_row[hi]) hi = i;
                end
            end
            if (!any) return 0;
            if (lo < 0) return longint'(signed'(key_val[hi]));
            if (hi < 0) return longint'(signed'(key_val[lo]));
            vl = longint'(signed'(key_val[lo]));
            vu = longint'(signed'(key_val[hi]));
            if (key_mode[lo] == MODE_STEP) return vl;
            span = key_row[hi] - key_row[lo];
            diff = longint'(qtime) - (longint'(key_row[lo]) << 16);
            t    = (diff / span) & 64'hFFFF;
            case (key_mode[lo])
                MODE_LINEAR: w = t;
                MODE_COSINE: w = ease[(t * COS_STEPS) >> 16];
                default:     w = (t * t) >> 16;
            endcase
            // Arithmetic shift gives the floor of the signed quotient.
            return vl + (((vu - vl) * longint'(w)) >>> 16);
        endfunction

        // Applies an accepted word to the table and queues its result.
        function void note_word(logic [OP_W-1:0] op, logic [ROW_W-1:0] row,
                                logic [VAL_W-1:0] val, logic [MODE_W-1:0] mode,
                                logic [TIME_W-1:0] qtime);
            t_result r;
            int idx;
            bit any;
            longint v;
            r   = '0;
            idx = slot_of(row);
            case (op)
                OP_SET: begin
                    if (idx >= 0) r.found = 1;
                    else begin
                        for (int i = 0; i < NUM_KEYS; i++)
                            if (!key_used[i]) begin
                                idx = i;
                                break;
                            end
                    end
                    if (idx >= 0) begin
                        if (!key_used[idx]) occupancy++;
                        key_row[idx]  = row;
                        key_val[idx]  = val;
                        key_mode[idx] = mode;
                        key_used[idx] = 1;
                    end else begin
                        r.status = 1;
                    end
                end
                OP_DELETE: begin
                    if (idx >= 0) begin
                        key_used[idx] = 0;
                        occupancy--;
                        r.found = 1;
                    end
                end
                OP_LOOKUP: begin
                    if (idx >= 0) begin
                        r.found = 1;
                        r.value = key_val[idx];
                        r.mode  = key_mode[idx];
                    end
                end
                default: begin
                    v       = sample_curve(qtime, any);
                    r.found = any;
                    r.value = v[31:0];
                end
            endcase
            pending.push_back(r);
        endfunction

        // Compares a result word with the oldest prediction.
        function void check_word(logic [39:0] data);
            t_result got, want;
            got.found  = data[0];
            got.value  = data[32:1];
            got.mode   = data[34:33];
            got.status = data[35];
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result word %h with nothing pending", data);
                return;
            end
            want = pending.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Mismatch: expected found %b value %h mode %0d status %b,",
                             want.found, want.value, want.mode, want.status,
                             " got found %b value %h mode %0d status %b",
                             got.found, got.value, got.mode, got.status);
            end
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [87:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [39:0] m_axis_tdata;

    keyframe_scoreboard keys = new();
    int send_idle = 0;
    int recv_idle = 0;
    int cycles = 0;
    logic [ROW_W-1:0] row_pool[POOL_SIZE];

    keyframe_track_interpolator #(
        .NUM_KEYS (NUM_KEYS),
        .COS_STEPS(COS_STEPS)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Result side: check accepted words, then pick the next ready level.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) keys.check_word(m_axis_tdata);
        m_axis_tready <= ($urandom_range(0, 99) >= recv_idle);
    end

    // Watchdog against a hung block.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Sends one word, with a random gap in front of it, and waits for accept.
    task automatic send_word(logic [OP_W-1:0] op, logic [ROW_W-1:0] row,
                             logic [VAL_W-1:0] val, logic [MODE_W-1:0] mode,
                             logic [TIME_W-1:0] qtime);
        int gap;
        gap = ($urandom_range(0, 99) < send_idle) ? $urandom_range(1, 4) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tdata  <= {6'b0, qtime, mode, val, row};
        s_axis_tuser  <= op;
        s_axis_tvalid <= 1;
        do @(posedge i_clk); while (!s_axis_tready);
        keys.note_word(op, row, val, mode, qtime);
    endtask

    // Holds the sender off until every pending result has come back.
    task automatic drain();
        s_axis_tvalid <= 0;
        while (keys.pending.size() != 0) @(posedge i_clk);
        @(posedge i_clk);
    endtask

    // One random word; set_pct biases toward filling the table.
    task automatic random_word(int set_pct);
        int pick;
        logic [OP_W-1:0] op;
        logic [ROW_W-1:0] row;
        logic [VAL_W-1:0] val;
        logic [TIME_W-1:0] qtime;
        pick = $urandom_range(0, 99);
        if (pick < set_pct) op = OP_SET;
        else if (pick < set_pct + (100 - set_pct) / 4) op = OP_DELETE;
        else if (pick < set_pct + (100 - set_pct) / 2) op = OP_LOOKUP;
        else op = OP_EVAL;
        row = ($urandom_range(0, 9) == 0) ? ROW_W'($urandom())
                                          : row_pool[$urandom_range(0, POOL_SIZE - 1)];
        case ($urandom_range(0, 9))
            0:       val = 32'h8000_0000;
            1:       val = 32'h7FFF_FFFF;
            default: val = $urandom();
        endcase
        qtime = ($urandom_range(0, 4) == 0) ? $urandom()
              : {row_pool[$urandom_range(0, POOL_SIZE - 1)], 16'($urandom())};
        send_word(op, row, val, MODE_W'($urandom()), qtime);
    endtask

    initial begin
        foreach (row_pool[i]) row_pool[i] = ROW_W'($urandom());
        row_pool[0] = '0;
        row_pool[1] = '1;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed words: empty table, extremes, every mode and the edge cases.
        send_idle = 35;
        recv_idle = 62;
        send_word(OP_EVAL,   16'd5,     '0,           MODE_STEP,   32'h0005_8000);
        send_word(OP_LOOKUP, 16'd7,     '0,           MODE_STEP,   '0);
        send_word(OP_DELETE, 16'd7,     '0,           MODE_STEP,   '0);
        send_word(OP_SET,    16'd0,     32'h8000_0000, MODE_STEP,  '0);
        send_word(OP_SET,    16'hFFFF,  32'h7FFF_FFFF, MODE_LINEAR, '0);
        send_word(OP_LOOKUP, 16'd0,     '0,           MODE_STEP,   '0);
        send_word(OP_LOOKUP, 16'hFFFF,  '0,           MODE_STEP,   '0);
        send_word(OP_EVAL,   16'd0,     '0,           MODE_STEP,   32'h0000_0000);
        send_word(OP_EVAL,   16'd0,     '0,           MODE_STEP,   32'hFFFF_FFFF);
        send_word(OP_EVAL,   16'd0,     '0,           MODE_STEP,   32'h7FFF_0000);
        send_word(OP_SET,    16'd100,   32'h0001_0000, MODE_COSINE, '0);
        send_word(OP_SET,    16'd200,   32'hFFF0_0000, MODE_RAMP,  '0);
        send_word(OP_SET,    16'd300,   32'h0123_4567, MODE_LINEAR, '0);
        send_word(OP_DELETE, 16'd0,     '0,           MODE_STEP,   '0);
        send_word(OP_EVAL,   16'd0,     '0,           MODE_STEP,   32'h0032_0000);
        send_word(OP_SET,    16'd100,   32'h0005_0000, MODE_COSINE, '0);
        send_word(OP_EVAL,   16'd0,     '0,           MODE_STEP,   32'h0096_8000);
        send_word(OP_EVAL,   16'd0,     '0,           MODE_STEP,   32'h00C7_FFFF);
        send_word(OP_EVAL,   16'd0,     '0,           MODE_STEP,   32'h00FA_1234);
        send_word(OP_EVAL,   16'd0,     '0,           MODE_STEP,   32'h8000_0000);
        send_word(OP_SET,    16'd50,    32'hFFFF_FFFF, MODE_STEP,  '0);
        send_word(OP_EVAL,   16'd0,     '0,           MODE_STEP,   32'h004B_0000);
        send_word(OP_LOOKUP, 16'd100,   '0,           MODE_STEP,   '0);
        drain();

        // Random phases: fill toward full, then mixed traffic.
        for (int n = 0; n < 200; n++) random_word(n < 120 ? 75 : 40);
        drain();
        send_idle = 62;
        recv_idle = 35;
        for (int n = 0; n < 200; n++) random_word(n < 60 ? 70 : 35);
        drain();
        send_idle = 0;
        recv_idle = 0;
        for (int n = 0; n < 200; n++) random_word(n < 80 ? 75 : 30);
        s_axis_tvalid <= 0;

        while (keys.pending.size() != 0) @(posedge i_clk);
        repeat (120) @(posedge i_clk);
        if (keys.mismatches == 0 && keys.pending.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
